### rtl/kmsd_pkg.sv
// shared constants, types and key map of the keypad matrix scan decoder
package kmsd_pkg;

    // matrix geometry: bit row*ROW_STRIDE+column of a scan
    localparam int ROWS       = 3;
    localparam int COLUMNS    = 8;
    localparam int ROW_STRIDE = 8;
    localparam int NUM_KEYS   = 24;
    localparam int KEY_W      = $clog2(NUM_KEYS + 1);
    localparam int ROW_W      = $clog2(ROW_STRIDE);

    // beat layouts
    localparam int KEYS_W   = 24;
    localparam int TIME_W   = 32;
    localparam int CODE_W   = 8;
    localparam int THRESH_W = 16;
    localparam int IN_W     = 56;
    localparam int OUT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STORE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DATA      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GO        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd7;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd1000;

    // special keys
    localparam logic [KEY_W-1:0] STEP_INDEX  = 5'd16;
    localparam logic [KEY_W-1:0] PLUS_INDEX  = 5'd19;
    localparam logic [KEY_W-1:0] LEFT_INDEX  = 5'd20;
    localparam logic [KEY_W-1:0] RIGHT_INDEX = 5'd21;

    localparam logic [CODE_W-1:0] LEFT_CODE  = 8'h3C;
    localparam logic [CODE_W-1:0] RIGHT_CODE = 8'h3E;

    typedef logic [REG_STEP:REG_STORE][CODE_W-1:0] code_bank_t;

    // per-lane findings
    typedef struct packed {
        logic              pressed;
        logic              is_plus;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] long_code;
    } lane_out_t;

    // merged view of one scan
    typedef struct packed {
        logic              any;
        logic              multi;
        logic [KEY_W-1:0]  idx;
        logic              is_plus;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] long_code;
    } merge_t;

    // true when a bit position lies inside the scanned rows and columns
    function automatic logic in_matrix(input logic [KEY_W-1:0] idx);
        logic [KEY_W-1:0] row;
        logic [KEY_W-1:0] col;
        row = idx >> ROW_W;
        col = idx & KEY_W'(ROW_STRIDE - 1);
        return (int'(row) < ROWS) && (int'(col) < COLUMNS) && (int'(idx) < NUM_KEYS);
    endfunction

    // key map: fixed ascii codes, function keys from the code bank
    function automatic logic [CODE_W-1:0] map_key(input logic [KEY_W-1:0] idx,
                                                  input code_bank_t bank);
        logic [CODE_W-1:0] c;
        case (idx)
            5'd0:    c = bank[REG_STORE];
            5'd1:    c = 8'h36;
            5'd2:    c = 8'h35;
            5'd3:    c = 8'h34;
            5'd4:    c = 8'h33;
            5'd5:    c = 8'h32;
            5'd6:    c = 8'h31;
            5'd7:    c = 8'h30;
            5'd8:    c = bank[REG_RESET];
            5'd9:    c = 8'h44;
            5'd10:   c = 8'h43;
            5'd11:   c = 8'h42;
            5'd12:   c = 8'h41;
            5'd13:   c = 8'h39;
            5'd14:   c = 8'h38;
            5'd15:   c = 8'h37;
            5'd16:   c = bank[REG_STEP];
            5'd17:   c = bank[REG_COUNTER];
            5'd18:   c = bank[REG_GO];
            5'd19:   c = 8'h2B;
            5'd20:   c = bank[REG_DATA];
            5'd21:   c = bank[REG_ADDRESS];
            5'd22:   c = 8'h46;
            5'd23:   c = 8'h45;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### rtl/kmsd_lane.sv
// one key lane: gates the key bit and looks up its codes
module kmsd_lane
    import kmsd_pkg::*;
(
    input  logic             key_bit,
    input  logic [KEY_W-1:0] lane_idx,
    input  code_bank_t       bank,
    output lane_out_t        lane_out
);

    // press, plus flag and short code
    always_comb
    begin
        lane_out.pressed = key_bit & in_matrix(lane_idx);
        lane_out.is_plus = (lane_idx == PLUS_INDEX);
        lane_out.code    = map_key(lane_idx, bank);
        // long-press code, zero for keys without one
        if (lane_idx == LEFT_INDEX)
        begin
            lane_out.long_code = LEFT_CODE;
        end
        else if (lane_idx == RIGHT_INDEX)
        begin
            lane_out.long_code = RIGHT_CODE;
        end
        else if (lane_idx == STEP_INDEX)
        begin
            lane_out.long_code = bank[REG_STEP];
        end
        else
        begin
            lane_out.long_code = '0;
        end
    end

endmodule

### rtl/kmsd_merge.sv
// merges the lanes: last pressed key in scan order and whether several are down
module kmsd_merge
    import kmsd_pkg::*;
(
    input  lane_out_t [NUM_KEYS-1:0] lanes,
    output merge_t                   merged
);

    // priority pick of the highest pressed lane
    always_comb
    begin
        merged = '0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (lanes[i].pressed)
            begin
                merged.multi     = merged.any;
                merged.any       = 1'b1;
                merged.idx       = KEY_W'(i);
                merged.is_plus   = lanes[i].is_plus;
                merged.code      = lanes[i].code;
                merged.long_code = lanes[i].long_code;
            end
        end
    end

endmodule

### rtl/keypad_matrix_scan_decoder.sv
// top level: configuration registers, key and hold-timer state, result register
//
// Each beat on the input is one full scan of the 3x8 key matrix with the
// millisecond time; each scan yields exactly one result beat (key code, zero
// when no event, and the plus-held flag). A scan is taken every clock cycle
// while the output is not stalled, and its result appears on the output in
// the cycle after: 24 key lanes and a merge stage resolve the scan as
// combinational logic, and the remembered key and hold timer are updated in
// that same cycle. The result register is the only buffer, so input ready
// follows output ready while a result waits. Configuration writes take effect
// at once; the user must make them while no scan is in flight (not enforced).
module keypad_matrix_scan_decoder
    import kmsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // scan input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // pressed_keys[23:0], now_ms[55:24]
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata    // key_code[7:0], plus_held[8], zero[15:9]
);

    logic [THRESH_W-1:0]   thresh_reg;
    code_bank_t            bank_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [KEY_W-1:0]      key_next;
    logic [TIME_W-1:0]     start_reg;
    logic [TIME_W-1:0]     start_next;
    logic                  out_valid_reg;
    logic [CODE_W-1:0]     out_code_reg;
    logic [CODE_W-1:0]     out_code_next;
    logic                  out_plus_reg;
    logic                  out_plus_next;
    logic                  accept;
    logic [KEYS_W-1:0]     keys;
    logic [TIME_W-1:0]     now;
    logic [TIME_W-1:0]     elapsed;
    logic                  held;
    logic                  same_key;
    lane_out_t [NUM_KEYS-1:0] lanes;
    merge_t                merged;

    assign keys     = s_tdata[KEYS_W-1:0];
    assign now      = s_tdata[KEYS_W +: TIME_W];
    assign s_tready = ~out_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESHOLD_RESET;
            for (int i = REG_STORE; i <= REG_STEP; i++)
            begin
                bank_reg[i] <= CODE_W'(127 + i);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_THRESHOLD)
            begin
                thresh_reg <= cfg_data[THRESH_W-1:0];
            end
            else
            begin
                bank_reg[cfg_index] <= cfg_data[CODE_W-1:0];
            end
        end
    end

    // one lane per key
    for (genvar g = 0; g < NUM_KEYS; g++)
    begin : g_lane
        kmsd_lane u_lane (
            .key_bit  (keys[g]),
            .lane_idx (KEY_W'(g)),
            .bank     (bank_reg),
            .lane_out (lanes[g])
        );
    end

    kmsd_merge u_merge (
        .lanes  (lanes),
        .merged (merged)
    );

    // hold timer with wrapping difference
    assign elapsed  = now - start_reg;
    assign held     = elapsed > {{(TIME_W-THRESH_W){1'b0}}, thresh_reg};
    assign same_key = ~merged.multi & (key_reg == (merged.idx + KEY_W'(1)));

    // scan resolution: with several keys down the last one always differs
    always_comb
    begin
        key_next      = key_reg;
        start_next    = start_reg;
        out_code_next = '0;
        out_plus_next = merged.any & merged.is_plus;
        if (!merged.any)
        begin
            key_next = '0;
        end
        else if (!same_key)
        begin
            key_next      = merged.idx + KEY_W'(1);
            out_code_next = merged.code;
            start_next    = now;
        end
        else if (held)
        begin
            out_code_next = merged.long_code;
            start_next    = now;
        end
    end

    // key state and timer start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            start_reg <= '0;
        end
        else if (accept)
        begin
            key_reg   <= key_next;
            start_reg <= start_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_code_reg <= out_code_next;
            out_plus_reg <= out_plus_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-CODE_W-1){1'b0}}, out_plus_reg, out_code_reg};

    // remembered key stays a valid key number
    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(key_reg) <= NUM_KEYS)
        else $error("remembered key out of range");

    // an empty scan forgets the remembered key
    a_empty_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (keys == '0) |=> key_reg == '0)
        else $error("empty scan kept a remembered key");

    // plus flag shown only while plus is the remembered key
    a_plus_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_plus_reg |-> key_reg == (PLUS_INDEX + KEY_W'(1)))
        else $error("plus flag without plus key remembered");

    // every reported event restarts the hold timer
    a_event_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (out_code_next != '0) |=> start_reg == $past(now))
        else $error("key event did not restart hold timer");

    // an accepted scan always yields a result beat
    a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted scan produced no result");

endmodule

### dv/testbench.sv
// testbench for the keypad matrix scan decoder: directed and random scans checked beat by beat
`timescale 1ns / 100ps

module testbench;
    import kmsd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // function keys without a named index in the package
    localparam int STORE_KEY   = 0;
    localparam int RESET_KEY   = 8;
    localparam int COUNTER_KEY = 17;
    localparam int GO_KEY      = 18;

    // fixed ascii codes by key index, zero where a code register decides
    localparam logic [CODE_W-1:0] KEY_CHARS [NUM_KEYS] = '{
        8'h00, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30,
        8'h00, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38, 8'h37,
        8'h00, 8'h00, 8'h00, 8'h2B, 8'h00, 8'h00, 8'h46, 8'h45
    };

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              plus;
    } scan_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;   // pressed_keys[23:0], now_ms[55:24]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;   // key_code[7:0], plus_held[8], zero[15:9]

    // predictor state and register copy
    logic [KEY_W-1:0]    held_key;
    logic [TIME_W-1:0]   hold_start_ms;
    logic [THRESH_W-1:0] hold_limit_ms;
    code_bank_t          fn_codes;

    scan_result_t expected_codes [$];
    int           mismatch_count;
    int           cycle_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    logic [TIME_W-1:0] scan_time_ms;

    keypad_matrix_scan_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("keypad_matrix_scan_decoder test failed");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // code a single key press maps to
    function automatic logic [CODE_W-1:0] key_code_of(input int idx);
        case (idx)
            STORE_KEY:   return fn_codes[REG_STORE];
            RESET_KEY:   return fn_codes[REG_RESET];
            STEP_INDEX:  return fn_codes[REG_STEP];
            COUNTER_KEY: return fn_codes[REG_COUNTER];
            GO_KEY:      return fn_codes[REG_GO];
            LEFT_INDEX:  return fn_codes[REG_DATA];
            RIGHT_INDEX: return fn_codes[REG_ADDRESS];
            default:     return KEY_CHARS[idx];
        endcase
    endfunction

    // walk one scan in row-major order, updating held key and hold timer
    function automatic scan_result_t decode_scan(input logic [KEYS_W-1:0] keys,
                                                 input logic [TIME_W-1:0] now);
        scan_result_t      res;
        logic              any_down;
        logic [KEY_W-1:0]  slot;
        logic [TIME_W-1:0] elapsed;
        int                idx;
        res      = '0;
        any_down = 1'b0;
        for (int row = 0; row < ROWS; row++)
        begin
            for (int col = 0; col < COLUMNS; col++)
            begin
                idx = row * ROW_STRIDE + col;
                if (idx < NUM_KEYS && keys[idx])
                begin
                    any_down = 1'b1;
                    slot     = KEY_W'(idx + 1);
                    res.plus = (idx == PLUS_INDEX);
                    elapsed  = now - hold_start_ms;
                    if (slot != held_key)
                    begin
                        held_key      = slot;
                        res.code      = key_code_of(idx);
                        hold_start_ms = now;
                    end
                    else if (elapsed > TIME_W'(hold_limit_ms))
                    begin
                        // long press: timer restarts for every key, three keys repeat
                        if (idx == LEFT_INDEX)
                            res.code = LEFT_CODE;
                        if (idx == RIGHT_INDEX)
                            res.code = RIGHT_CODE;
                        if (idx == STEP_INDEX)
                            res.code = fn_codes[REG_STEP];
                        hold_start_ms = now;
                    end
                end
            end
        end
        // empty scan forgets the key
        if (!any_down)
        begin
            held_key = '0;
            res.plus = 1'b0;
        end
        return res;
    endfunction

    // send one scan beat and queue its predicted result
    task automatic send_scan(input logic [KEYS_W-1:0] keys, input logic [TIME_W-1:0] now);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, keys};
        do
            @(posedge clk);
        while (!s_tready);
        expected_codes.push_back(decode_scan(keys, now));
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write all registers while idle
    task automatic program_regs(input logic [THRESH_W-1:0] limit_ms, input code_bank_t codes);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_THRESHOLD;
        cfg_data  <= limit_ms;
        for (int r = REG_STORE; r <= REG_STEP; r++)
        begin
            @(negedge clk);
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= CFG_DATA_W'(codes[r]);
        end
        @(negedge clk);
        cfg_we        <= 1'b0;
        hold_limit_ms = limit_ms;
        fn_codes      = codes;
    endtask

    // single keys, all keys, plus flag ordering, empty scans
    task automatic test_single_keys();
        send_scan(24'h000000, 32'd0);
        send_scan(24'hFFFFFF, 32'hFFFF_FFFF);
        send_scan(24'hFFFFFF, 32'hFFFF_FFFF);
        send_scan(24'h000080, 32'd10);
        send_scan(24'h008000, 32'd11);
        send_scan(24'h080000, 32'd12);
        send_scan(24'h880000, 32'd13);
        send_scan(24'h080008, 32'd14);
        send_scan(24'h000101, 32'd15);
        send_scan(24'h000000, 32'd16);
    endtask

    // hold timer at its boundary, long-press codes, time wrap
    task automatic test_long_press();
        send_scan(24'h010000, 32'd100);
        send_scan(24'h010000, 32'd1100);
        send_scan(24'h010000, 32'd1101);
        send_scan(24'h100000, 32'd2000);
        send_scan(24'h100000, 32'd3001);
        // hold off until the pipeline is empty
        drain_results();
        send_scan(24'h200000, 32'd3002);
        send_scan(24'h200000, 32'd4003);
        send_scan(24'h000004, 32'd5000);
        send_scan(24'h000004, 32'd6001);
        send_scan(24'h000004, 32'd7001);
        send_scan(24'h010000, 32'hFFFF_FF00);
        send_scan(24'h010000, 32'h0000_0300);
    endtask

    // threshold and code registers at their extremes
    task automatic test_register_extremes();
        code_bank_t codes;
        codes              = '0;
        codes[REG_RESET]   = 8'hFF;
        codes[REG_STEP]    = 8'h01;
        drain_results();
        program_regs('0, codes);
        send_scan(24'h000001, 32'd50);
        send_scan(24'h000100, 32'd51);
        send_scan(24'h010000, 32'd52);
        send_scan(24'h010000, 32'd52);
        send_scan(24'h010000, 32'd53);
        drain_results();
        program_regs('1, '1);
        send_scan(24'h100000, 32'd0);
        send_scan(24'h100000, 32'd65535);
        send_scan(24'h100000, 32'd65536);
    endtask

    // one register setting per random run
    task automatic apply_setting(input int which);
        code_bank_t          codes;
        logic [THRESH_W-1:0] limit_ms;
        for (int r = REG_STORE; r <= REG_STEP; r++)
            codes[r] = CODE_W'($urandom_range(1, 255));
        case (which)
            0:
            begin
                limit_ms         = '0;
                codes[REG_STORE] = 8'h01;
                codes[REG_STEP]  = 8'hFF;
            end
            1:
            begin
                limit_ms = '1;
                codes    = '1;
            end
            2: limit_ms = 16'd3;
            3:
            begin
                limit_ms        = 16'd20;
                codes[REG_DATA] = '0;
                codes[REG_STEP] = '0;
            end
            4: limit_ms = THRESHOLD_RESET;
            default: limit_ms = THRESH_W'($urandom_range(0, 65535));
        endcase
        drain_results();
        program_regs(limit_ms, codes);
    endtask

    // keys to hold: mostly one key, favoring the long-press and plus keys
    function automatic logic [KEYS_W-1:0] pick_key_set();
        logic [KEYS_W-1:0] keys;
        keys = '0;
        case ($urandom_range(0, 7))
            0: keys[STEP_INDEX]  = 1'b1;
            1: keys[LEFT_INDEX]  = 1'b1;
            2: keys[RIGHT_INDEX] = 1'b1;
            3: keys[PLUS_INDEX]  = 1'b1;
            4, 5: keys[$urandom_range(0, NUM_KEYS - 1)] = 1'b1;
            6:
            begin
                keys[$urandom_range(0, NUM_KEYS - 1)] = 1'b1;
                keys[$urandom_range(0, NUM_KEYS - 1)] = 1'b1;
            end
            default: keys = KEYS_W'($urandom() & $urandom() & $urandom());
        endcase
        return keys;
    endfunction

    // time advance between scans, clustered around the threshold
    function automatic logic [TIME_W-1:0] next_step();
        case ($urandom_range(0, 3))
            0: return TIME_W'($urandom_range(0, hold_limit_ms / 2));
            1: return TIME_W'(hold_limit_ms) + TIME_W'($urandom_range(0, 4)) - 32'd2;
            2: return TIME_W'($urandom_range(0, 2 * hold_limit_ms + 10));
            default: return '0;
        endcase
    endfunction

    // held-key sequences with random timing, plus random noise scans
    task automatic test_random_holds(input int n_items);
        logic [KEYS_W-1:0] keys;
        int                hold_len;
        int                sent;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                if ($urandom_range(0, 19) == 0)
                    scan_time_ms = $urandom() | 32'hFFFF_0000;
                keys     = pick_key_set();
                hold_len = $urandom_range(1, 8);
                for (int h = 0; h < hold_len; h++)
                begin
                    scan_time_ms += next_step();
                    send_scan(keys, scan_time_ms);
                    sent++;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    scan_time_ms += TIME_W'($urandom_range(0, 50));
                    send_scan('0, scan_time_ms);
                    sent++;
                end
            end
            else
            begin
                send_scan(KEYS_W'($urandom()), $urandom());
                sent++;
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_codes.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result beat: expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                want = expected_codes.pop_front();
                if (m_tdata[CODE_W-1:0] !== want.code)
                begin
                    mismatch_count++;
                    $display("%0t: key_code mismatch: expected %h, actual %h",
                             $time, want.code, m_tdata[CODE_W-1:0]);
                end
                if (m_tdata[CODE_W] !== want.plus)
                begin
                    mismatch_count++;
                    $display("%0t: plus_held mismatch: expected %b, actual %b",
                             $time, want.plus, m_tdata[CODE_W]);
                end
            end
        end
    end

    // test sequence
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_THRESHOLD;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        scan_time_ms   = '0;
        held_key       = '0;
        hold_start_ms  = '0;
        hold_limit_ms  = THRESHOLD_RESET;
        for (int r = REG_STORE; r <= REG_STEP; r++)
            fn_codes[r] = CODE_W'(127 + r);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_keys();
        test_long_press();
        test_register_extremes();

        // random runs: receiver idles more, then sender idles more, then no idling
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 51 : 0;
            recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 13 : 0;
            for (int half = 0; half < 2; half++)
            begin
                apply_setting(phase * 2 + half);
                test_random_holds(225);
            end
        end

        drain_results();
        if (mismatch_count == 0)
            $display("keypad_matrix_scan_decoder test passed");
        else
            $display("keypad_matrix_scan_decoder test failed");
        $finish;
    end

endmodule
